/* rtl/interval_remap_splitter_macros.svh */
// Assertion macros used by the interval remap splitter RTL.
`ifndef INTERVAL_REMAP_SPLITTER_MACROS_SVH
`define INTERVAL_REMAP_SPLITTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ISR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ISR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/isr_pkg.sv */
// Shared constants, types and command format of the interval remap splitter.
package isr_pkg;

	localparam int MAX_WINDOWS = 16;
	localparam int VALUE_BITS  = 48;
	localparam int CFG_W       = 5;
	localparam int ENTRY_W     = 4;
	localparam int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
	localparam int QUEUE_DEPTH = 2;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [VALUE_BITS:0]   wide_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_XLATE = 1'b1
	} op_t;

	// Load: base = source start, shift = target - source, limit = window end.
	// Translate: base = range start, limit = range end, shift unused.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] slot;
		wide_t            base;
		value_t           shift;
		wide_t            limit;
	} cmd_t;

	typedef struct packed {
		value_t start;
		value_t length;
		logic   mapped;
		logic   last;
	} piece_t;

endpackage

/* rtl/isr_fifo.sv */
// Short command queue between the front and back parts of the splitter.
module isr_fifo
	import isr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign full     = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/isr_front.sv */
// Front part: accept items, classify them and precompute window and range ends.
module isr_front
	import isr_pkg::*;
(
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [ENTRY_W-1:0] entry_index,
	input  value_t             window_source,
	input  value_t             window_target,
	input  value_t             window_length,
	input  value_t             range_start,
	input  value_t             range_length,
	input  logic               full,
	output logic               push,
	output cmd_t               push_data
);

	logic accept;
	logic slot_ok;
	logic keep;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign slot_ok  = 32'(entry_index) < 32'(MAX_WINDOWS);

	// Drop loads beyond the table and empty ranges: neither has any effect.
	always_comb begin
		push_data = '0;
		keep      = 1'b0;
		case (op_t'(op))
			OP_LOAD: begin
				keep            = slot_ok;
				push_data.op    = OP_LOAD;
				push_data.slot  = IDX_W'(entry_index);
				push_data.base  = {1'b0, window_source};
				push_data.shift = window_target - window_source;
				push_data.limit = {1'b0, window_source} + {1'b0, window_length};
			end
			OP_XLATE: begin
				keep            = (range_length != '0);
				push_data.op    = OP_XLATE;
				push_data.base  = {1'b0, range_start};
				push_data.limit = {1'b0, range_start} + {1'b0, range_length};
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = accept && keep;

endmodule

/* rtl/isr_back.sv */
// Back part: window table, range walk and the output piece register.
`include "interval_remap_splitter_macros.svh"

module isr_back
	import isr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] window_count,
	input  logic             empty,
	input  cmd_t             pop_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output value_t           piece_start,
	output value_t           piece_length,
	output logic             piece_mapped,
	output logic             last
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_WALK = 2'b10
	} bstate_t;

	// Window table, undefined until loaded
	wide_t  src_q   [MAX_WINDOWS];
	wide_t  wend_q  [MAX_WINDOWS];
	value_t delta_q [MAX_WINDOWS];

	bstate_t          state_q;
	logic [CNT_W-1:0] idx_q;
	wide_t            start_q;
	wide_t            end_q;
	logic             out_valid_q;
	piece_t           out_q;

	logic [CNT_W-1:0] count_lim;
	logic             slot_free;
	logic             step;
	logic             at_end;
	wide_t            w_src;
	wide_t            w_end;
	value_t           w_delta;
	value_t           len_all;
	logic             emit;
	logic             adv;
	logic             go_idle;
	wide_t            start_nxt;
	piece_t           piece;

	assign count_lim = (window_count > CFG_W'(MAX_WINDOWS)) ? CNT_W'(MAX_WINDOWS)
		: CNT_W'(window_count);
	assign slot_free = !out_valid_q || out_ready;
	assign step      = (state_q == B_WALK) && slot_free;
	assign pop       = (state_q == B_IDLE) && !empty;

	assign at_end  = (idx_q == count_lim);
	assign w_src   = src_q[idx_q[IDX_W-1:0]];
	assign w_end   = wend_q[idx_q[IDX_W-1:0]];
	assign w_delta = delta_q[idx_q[IDX_W-1:0]];
	assign len_all = value_t'(end_q - start_q);

	// One window per step, at most one piece per step. A prefix gap before a
	// window takes its own step, then the same window is looked at again.
	always_comb begin
		emit      = 1'b0;
		adv       = 1'b0;
		go_idle   = 1'b0;
		start_nxt = start_q;
		piece     = '0;
		if (at_end) begin
			emit    = 1'b1;
			go_idle = 1'b1;
			piece   = '{start: value_t'(start_q), length: len_all, mapped: 1'b0, last: 1'b1};
		end else if (end_q <= w_src) begin
			emit    = 1'b1;
			go_idle = 1'b1;
			piece   = '{start: value_t'(start_q), length: len_all, mapped: 1'b0, last: 1'b1};
		end else if (start_q >= w_end) begin
			adv = 1'b1;
		end else if (start_q < w_src) begin
			emit      = 1'b1;
			start_nxt = w_src;
			piece     = '{start: value_t'(start_q), length: value_t'(w_src - start_q),
				mapped: 1'b0, last: 1'b0};
		end else if (end_q <= w_end) begin
			emit    = 1'b1;
			go_idle = 1'b1;
			piece   = '{start: value_t'(start_q) + w_delta, length: len_all,
				mapped: 1'b1, last: 1'b1};
		end else begin
			emit      = 1'b1;
			adv       = 1'b1;
			start_nxt = w_end;
			piece     = '{start: value_t'(start_q) + w_delta,
				length: value_t'(w_end - start_q), mapped: 1'b1, last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop && pop_data.op == OP_XLATE) begin
						state_q <= B_WALK;
						idx_q   <= '0;
					end
				end
				B_WALK: begin
					if (step) begin
						if (adv) begin
							idx_q <= idx_q + CNT_W'(1);
						end
						if (go_idle) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_data.op == OP_LOAD) begin
			src_q[pop_data.slot]   <= pop_data.base;
			wend_q[pop_data.slot]  <= pop_data.limit;
			delta_q[pop_data.slot] <= pop_data.shift;
		end
		if (pop && pop_data.op == OP_XLATE) begin
			start_q <= pop_data.base;
			end_q   <= pop_data.limit;
		end else if (step) begin
			start_q <= start_nxt;
		end
		if (step && emit) begin
			out_q <= piece;
		end
	end

	assign out_valid    = out_valid_q;
	assign piece_start  = out_q.start;
	assign piece_length = out_q.length;
	assign piece_mapped = out_q.mapped;
	assign last         = out_q.last;

	`ISR_ASSERT_IMPL(a_idx_bound, state_q == B_WALK, idx_q <= count_lim, "walk index past count")
	`ISR_ASSERT_IMPL(a_walk_nonempty, state_q == B_WALK, start_q < end_q, "walk with empty range")
	`ISR_ASSERT_IMPL(a_piece_from_walk, $rose(out_valid_q), $past(state_q) == B_WALK,
		"piece not from walk")
	`ISR_ASSERT_NEXT(a_last_ends_walk, step && emit && piece.last, state_q == B_IDLE,
		"walk continues after last piece")

endmodule

/* rtl/interval_remap_splitter.sv */
// Top level of the interval remap splitter: window count register, front, queue, back.
//
// Usage: load windows with op = 0 items (slot, source, target, length) in
// ascending source order, set window_count through cfg_we/cfg_wdata while the
// block is idle, then send op = 1 items with a range (start, length). Each
// range comes out as a run of pieces on the output channel, in ascending
// source order: covered pieces shifted to the target and flagged mapped,
// gaps passed through unmapped; the final piece carries last. An empty range
// or a load to a slot beyond the table gives no piece.
// Input side: the front takes an item whenever the two-entry queue has room,
// so it keeps accepting while the back part walks or the receiver stalls.
// An idle back part pops an item in the cycle after acceptance. Its first piece
// enters the output register once the walk has skipped the windows before it.
// A load is written to the table when popped. A translate walks the windows in
// order, at most one piece per step: each window skipped or fully crossed, each
// unmapped gap before a window and a trailing unmapped piece takes its own step.
// The back part pops no new item until the walk of a range ends.
// Receiver stall: the output register holds the piece and the walk freezes.
// Reset: clears the window count, queue and output valid; table is not cleared.
module interval_remap_splitter
	import isr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [ENTRY_W-1:0] entry_index,
	input  value_t             window_source,
	input  value_t             window_target,
	input  value_t             window_length,
	input  value_t             range_start,
	input  value_t             range_length,
	output logic               out_valid,
	input  logic               out_ready,
	output value_t             piece_start,
	output value_t             piece_length,
	output logic               piece_mapped,
	output logic               last
);

	logic [CFG_W-1:0] window_count_q;
	logic             q_push;
	cmd_t             q_push_data;
	logic             q_full;
	logic             q_pop;
	cmd_t             q_pop_data;
	logic             q_empty;

	// Hold the window count; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_count_q <= '0;
		end else if (cfg_we) begin
			window_count_q <= cfg_wdata;
		end
	end

	// Classify items and precompute ends
	isr_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.entry_index   (entry_index),
		.window_source (window_source),
		.window_target (window_target),
		.window_length (window_length),
		.range_start   (range_start),
		.range_length  (range_length),
		.full          (q_full),
		.push          (q_push),
		.push_data     (q_push_data)
	);

	// Decouple front and back
	isr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	// Store windows, walk ranges, drive pieces
	isr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_count (window_count_q),
		.empty        (q_empty),
		.pop_data     (q_pop_data),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.piece_start  (piece_start),
		.piece_length (piece_length),
		.piece_mapped (piece_mapped),
		.last         (last)
	);

endmodule
